@@ design/irpd_pkg.sv @@
// Shared types, constants and codes for the IR remote pulse decoder.
package irpd_pkg;

    // Frame layout
    localparam int FRAME_BITS       = 16;
    localparam int PAUSE_AFTER_BITS = 8;
    localparam int CNT_W            = $clog2(FRAME_BITS + 1);
    localparam int WORD_W           = 16;
    localparam int TS_W             = 32;

    // Configuration port
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_W-1:0] HDR_MIN_RESET = CFG_W'(8000);
    localparam logic [CFG_W-1:0] HDR_MAX_RESET = CFG_W'(9000);
    localparam logic [CFG_W-1:0] ONE_THR_RESET = CFG_W'(650);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HDR_MIN = 2'd0,
        CFG_HDR_MAX = 2'd1,
        CFG_ONE_THR = 2'd2
    } t_cfg_idx;

    // Item modes
    localparam logic MODE_EDGE  = 1'b0;
    localparam logic MODE_CLEAR = 1'b1;

    // Decoder phases
    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_HDR_LOW    = 3'd1,
        PH_HDR_HIGH   = 3'd2,
        PH_BIT_LOW    = 3'd3,
        PH_BIT_HIGH   = 3'd4,
        PH_PAUSE_LOW  = 3'd5,
        PH_PAUSE_HIGH = 3'd6
    } t_phase;

    typedef struct packed {
        logic            mode;
        logic            line_level;
        logic [TS_W-1:0] timestamp_us;
    } t_in_item;

    typedef struct packed {
        logic              frame_valid;
        logic [WORD_W-1:0] frame_word;
    } t_out_item;

    // Decoder settings as held in the register bank
    typedef struct packed {
        logic [CFG_W-1:0] header_min_us;
        logic [CFG_W-1:0] header_max_us;
        logic [CFG_W-1:0] one_threshold_us;
    } t_cfg;

    // Decoder status for checking
    typedef struct packed {
        t_phase           phase;
        logic [CNT_W-1:0] bit_count;
        logic             valid_flag;
    } t_fsm_status;

endpackage

@@ design/irpd_ifs.sv @@
// Valid/ready channel interfaces for edge requests and frame results.
interface irpd_in_if
    import irpd_pkg::*;
;
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface irpd_out_if
    import irpd_pkg::*;
;
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ design/irpd_cfg_regs.sv @@
// Configuration register bank for the IR remote pulse decoder.
module irpd_cfg_regs
    import irpd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_we,
    input  logic [CFG_IDX_W-1:0] i_idx,
    input  logic [CFG_W-1:0]     i_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    // Register writes; indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_min_us    <= HDR_MIN_RESET;
            r_cfg.header_max_us    <= HDR_MAX_RESET;
            r_cfg.one_threshold_us <= ONE_THR_RESET;
        end else if (i_we) begin
            case (i_idx)
                CFG_HDR_MIN: r_cfg.header_min_us    <= i_data;
                CFG_HDR_MAX: r_cfg.header_max_us    <= i_data;
                CFG_ONE_THR: r_cfg.one_threshold_us <= i_data;
                default:     ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ design/irpd_in_stage.sv @@
// Input register stage: captures one request per cycle while the held request can advance.
module irpd_in_stage
    import irpd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_item,
    input  logic     i_advance,
    output logic     o_valid,
    output t_in_item o_item
);

    logic     r_valid;
    t_in_item r_item;

    // Free when empty or when the held request moves on this cycle
    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload needs no reset
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

@@ design/irpd_fsm.sv @@
// Pulse timing state machine: phase, bit count, shift word, flag, reference time.
module irpd_fsm
    import irpd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  t_in_item    i_item,
    input  t_cfg        i_cfg,
    output t_out_item   o_result,
    output t_fsm_status o_status
);

    t_phase                r_phase, n_phase;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [FRAME_BITS-1:0] r_word, n_word;
    logic                  r_vflag, n_vflag;
    logic [TS_W-1:0]       r_ref, n_ref;

    logic [TS_W-1:0]  elapsed;
    logic [CNT_W-1:0] cnt_inc;
    logic             lvl;
    logic             hdr_ok;
    logic             bit_val;

    assign lvl     = i_item.line_level;
    assign elapsed = i_item.timestamp_us - r_ref;
    assign cnt_inc = r_cnt + CNT_W'(1);
    assign hdr_ok  = (elapsed > TS_W'(i_cfg.header_min_us))
                  && (elapsed < TS_W'(i_cfg.header_max_us));
    assign bit_val = (elapsed >= TS_W'(i_cfg.one_threshold_us));

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cnt   <= '0;
            r_word  <= '0;
            r_vflag <= 1'b0;
            r_ref   <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_word  <= n_word;
            r_vflag <= n_vflag;
            r_ref   <= n_ref;
        end
    end

    // Next state
    always_comb begin
        logic err;
        err     = 1'b0;
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_word  = r_word;
        n_vflag = r_vflag;
        n_ref   = r_ref;

        if (i_item.mode == MODE_CLEAR) begin
            n_vflag = 1'b0;
        end else if (!r_vflag) begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (!lvl) begin
                        n_phase = PH_HDR_LOW;
                        n_ref   = i_item.timestamp_us;
                    end else begin
                        err = 1'b1;
                    end
                end
                PH_HDR_LOW: begin
                    if (lvl && hdr_ok) n_phase = PH_HDR_HIGH;
                    else               err = 1'b1;
                end
                PH_HDR_HIGH: begin
                    if (!lvl) n_phase = PH_BIT_LOW;
                    else      err = 1'b1;
                end
                PH_BIT_LOW: begin
                    if (lvl) begin
                        n_phase = PH_BIT_HIGH;
                        n_ref   = i_item.timestamp_us;
                    end else begin
                        err = 1'b1;
                    end
                end
                PH_BIT_HIGH: begin
                    if (!lvl) begin
                        n_word = {r_word[FRAME_BITS-2:0], bit_val};
                        n_cnt  = cnt_inc;
                        if (cnt_inc == CNT_W'(PAUSE_AFTER_BITS)) begin
                            n_phase = PH_PAUSE_LOW;
                        end else if (cnt_inc >= CNT_W'(FRAME_BITS)) begin
                            n_phase = PH_IDLE;
                            n_vflag = 1'b1;
                            n_cnt   = '0;
                        end else begin
                            n_phase = PH_BIT_LOW;
                        end
                    end else begin
                        err = 1'b1;
                    end
                end
                PH_PAUSE_LOW: begin
                    if (lvl) n_phase = PH_PAUSE_HIGH;
                    else     err = 1'b1;
                end
                PH_PAUSE_HIGH: begin
                    if (!lvl) n_phase = PH_BIT_LOW;
                    else      err = 1'b1;
                end
                default: err = 1'b1;
            endcase
            // Unexpected level or bad header: drop the partial frame
            if (err) begin
                n_phase = PH_IDLE;
                n_cnt   = '0;
                n_word  = '0;
            end
        end
    end

    // Result reflects the state after this request
    assign o_result.frame_valid = n_vflag;
    assign o_result.frame_word  = WORD_W'(n_word);

    assign o_status.phase      = r_phase;
    assign o_status.bit_count  = r_cnt;
    assign o_status.valid_flag = r_vflag;

endmodule

@@ design/irpd_out_reg.sv @@
// Result register driving the output channel.
module irpd_out_reg
    import irpd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_out_item i_result,
    input  logic      i_ready,
    output logic      o_free,
    output logic      o_valid,
    output t_out_item o_item
);

    logic      r_valid;
    t_out_item r_item;

    // Can take a new result when empty or being drained
    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_item <= i_result;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

@@ design/ir_remote_pulse_decoder.sv @@
// Top level of the IR remote pulse decoder.
// Stages: input register, state update, result register; a request passes them in order.
// Throughput: one request per cycle while the receiver takes results.
// Every request gives exactly one result: valid flag and shift word after the update.
// Synchronous active-low reset: idle phase, count, word, flag and reference cleared,
// timing registers back to 8000, 9000 and 650 us; both pipeline stages emptied.
module ir_remote_pulse_decoder
    import irpd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    irpd_in_if.sink              i_edge,
    irpd_out_if.source           o_frame,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_cfg        cfg;
    logic        s1_valid;
    t_in_item    s1_item;
    logic        out_free;
    logic        step;
    t_out_item   result;
    t_fsm_status status;

    // A held request moves on whenever the result register can take it
    assign step = s1_valid && out_free;

    irpd_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    irpd_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_edge.valid),
        .o_ready   (i_edge.ready),
        .i_item    (i_edge.data),
        .i_advance (out_free),
        .o_valid   (s1_valid),
        .o_item    (s1_item)
    );

    irpd_fsm u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (s1_item),
        .i_cfg    (cfg),
        .o_result (result),
        .o_status (status)
    );

    irpd_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (s1_valid),
        .i_result (result),
        .i_ready  (o_frame.ready),
        .o_free   (out_free),
        .o_valid  (o_frame.valid),
        .o_item   (o_frame.data)
    );

    // Checks

    // An empty result register never holds back the input side
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_frame.valid |-> i_edge.ready)
        else $error("input stalled with empty result register");

    // A held frame parks the machine in idle with no partial count
    a_flag_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.valid_flag |-> (status.phase == PH_IDLE && status.bit_count == '0))
        else $error("frame flag set outside idle");

    // No bits are counted before the header has been seen
    a_cnt_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (status.phase == PH_IDLE || status.phase == PH_HDR_LOW
         || status.phase == PH_HDR_HIGH) |-> (status.bit_count == '0))
        else $error("bit count non-zero before data");

    // The flag can only rise on a step, and the result shows it at once
    a_flag_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(status.valid_flag) |-> ($past(step) && o_frame.valid && o_frame.data.frame_valid))
        else $error("frame flag rose without a matching result");

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the IR remote pulse decoder: edge requests in, frame status out.
`timescale 1ns / 100ps

module tb_top;
    import irpd_pkg::*;

    // Request layout of one well-formed frame: header low, header high, data bits
    // with the pause after PAUSE_AFTER_BITS bits
    localparam int unsigned FRAME_ITEMS = 3 + 2 * FRAME_BITS + 2;
    localparam int unsigned PAUSE_FALL  = 4 + 2 * PAUSE_AFTER_BITS;

    // Ways a generated frame can be spoilt
    localparam int unsigned FLAW_NONE   = 0;
    localparam int unsigned FLAW_LEVEL  = 1;
    localparam int unsigned FLAW_HEADER = 2;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    t_cfg_idx             cfg_idx;
    logic [CFG_W-1:0]     cfg_data;

    irpd_in_if  edge_ch ();
    irpd_out_if frame_ch ();

    // Decoder model state and timing settings
    t_phase               dec_phase;
    logic [CNT_W-1:0]     dec_bits;
    logic [WORD_W-1:0]    dec_word;
    logic                 dec_held;
    logic [TS_W-1:0]      dec_ref;
    logic [CFG_W-1:0]     cfg_hdr_min;
    logic [CFG_W-1:0]     cfg_hdr_max;
    logic [CFG_W-1:0]     cfg_one_thr;
    bit                   edge_ignored;

    t_out_item            frame_expect_q[$];
    int unsigned          mismatch_cnt;
    int unsigned          active_items;
    logic [TS_W-1:0]      line_time;
    bit                   src_idle_on;
    bit                   sink_idle_on;
    int unsigned          sink_hold_len;

    ir_remote_pulse_decoder i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_edge     (edge_ch),
        .o_frame    (frame_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

    // Frame status after one request, advancing the model
    function automatic t_out_item decode_edge(t_in_item req);
        logic [TS_W-1:0] span;
        logic            hit;
        t_out_item       res;
        span         = req.timestamp_us - dec_ref;
        edge_ignored = 1'b0;
        if (req.mode == MODE_CLEAR) begin
            dec_held = 1'b0;
        end else if (dec_held) begin
            edge_ignored = 1'b1;
        end else begin
            hit = 1'b0;
            case (dec_phase)
                PH_IDLE: if (!req.line_level) begin
                    hit       = 1'b1;
                    dec_phase = PH_HDR_LOW;
                    dec_ref   = req.timestamp_us;
                end
                PH_HDR_LOW: if (req.line_level && span > cfg_hdr_min && span < cfg_hdr_max) begin
                    hit       = 1'b1;
                    dec_phase = PH_HDR_HIGH;
                end
                PH_HDR_HIGH: if (!req.line_level) begin
                    hit       = 1'b1;
                    dec_phase = PH_BIT_LOW;
                end
                PH_BIT_LOW: if (req.line_level) begin
                    hit       = 1'b1;
                    dec_phase = PH_BIT_HIGH;
                    dec_ref   = req.timestamp_us;
                end
                PH_BIT_HIGH: if (!req.line_level) begin
                    hit      = 1'b1;
                    dec_word = {dec_word[WORD_W-2:0], span >= cfg_one_thr};
                    dec_bits = dec_bits + CNT_W'(1);
                    if (dec_bits == PAUSE_AFTER_BITS) begin
                        dec_phase = PH_PAUSE_LOW;
                    end else if (dec_bits >= FRAME_BITS) begin
                        dec_phase = PH_IDLE;
                        dec_held  = 1'b1;
                        dec_bits  = '0;
                    end else begin
                        dec_phase = PH_BIT_LOW;
                    end
                end
                PH_PAUSE_LOW: if (req.line_level) begin
                    hit       = 1'b1;
                    dec_phase = PH_PAUSE_HIGH;
                end
                PH_PAUSE_HIGH: if (!req.line_level) begin
                    hit       = 1'b1;
                    dec_phase = PH_BIT_LOW;
                end
                default: ;
            endcase
            // wrong level or header length: back to idle, word and count dropped
            if (!hit) begin
                dec_word  = '0;
                dec_bits  = '0;
                dec_phase = PH_IDLE;
            end
        end
        res.frame_valid = dec_held;
        res.frame_word  = dec_word;
        return res;
    endfunction

    // Mostly no gap, often a short one, now and then a long one
    function automatic int unsigned idle_len();
        int unsigned pick;
        int unsigned len;
        pick = $urandom_range(0, 99);
        if (pick < 60)      len = 0;
        else if (pick < 95) len = $urandom_range(1, 3);
        else                len = $urandom_range(20, 60);
        return len;
    endfunction

    // Header low length, inside the window when asked and possible
    function automatic int unsigned header_len(bit good);
        int unsigned lo;
        int unsigned hi;
        int unsigned len;
        lo = cfg_hdr_min;
        hi = cfg_hdr_max;
        if (good && hi > lo + 1) begin
            case ($urandom_range(0, 3))
                0:       len = lo + 1;
                1:       len = hi - 1;
                default: len = $urandom_range(lo + 1, hi - 1);
            endcase
        end else begin
            case ($urandom_range(0, 3))
                0:       len = lo;
                1:       len = hi;
                2:       len = $urandom_range(0, lo);
                default: len = hi + $urandom_range(0, 1000);
            endcase
        end
        return len;
    endfunction

    // High pulse length for a data bit, hugging the threshold often
    function automatic int unsigned bit_len(logic one);
        int unsigned thr;
        int unsigned len;
        thr = cfg_one_thr;
        if (one || thr == 0) begin
            case ($urandom_range(0, 3))
                0:       len = thr;
                1:       len = thr + $urandom_range(1, 2000);
                2:       len = 32'h0001_0000 + $urandom_range(0, 100000);
                default: len = thr + $urandom_range(0, 300);
            endcase
        end else if ($urandom_range(0, 1) == 0) begin
            len = thr - 1;
        end else begin
            len = $urandom_range(0, thr - 1);
        end
        return len;
    endfunction

    task automatic note_mismatch(string what, logic [31:0] exp_val, logic [31:0] act_val);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("%0t: frame result %s: expected %h, got %h", $time, what, exp_val, act_val);
    endtask

    // Offer one request and predict its result once it is taken
    task automatic send_request(logic mode, logic level, logic [TS_W-1:0] ts);
        t_in_item    req;
        int unsigned gap;
        req.mode         = mode;
        req.line_level   = level;
        req.timestamp_us = ts;
        gap = src_idle_on ? idle_len() : 0;
        if (gap != 0) begin
            edge_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        edge_ch.valid <= 1'b1;
        edge_ch.data  <= req;
        @(posedge i_clk);
        while (edge_ch.ready !== 1'b1) @(posedge i_clk);
        frame_expect_q.push_back(decode_edge(req));
        if (!edge_ignored) active_items++;
    endtask

    // Stop offering and wait for every outstanding result
    task automatic wait_drained();
        edge_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (frame_expect_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            CFG_HDR_MIN: cfg_hdr_min = val;
            CFG_HDR_MAX: cfg_hdr_max = val;
            CFG_ONE_THR: cfg_one_thr = val;
            default: ;
        endcase
    endtask

    task automatic set_timing(logic [CFG_W-1:0] hmin, logic [CFG_W-1:0] hmax,
                              logic [CFG_W-1:0] thr);
        wait_drained();
        write_reg(CFG_HDR_MIN, hmin);
        write_reg(CFG_HDR_MAX, hmax);
        write_reg(CFG_ONE_THR, thr);
        cfg_we <= 1'b0;
    endtask

    // One frame with a random word; a flaw ends it early
    task automatic send_frame(int unsigned flaw, int unsigned flaw_at);
        logic [WORD_W-1:0] word;
        logic              lvl;
        int unsigned       dur;
        int unsigned       bit_no;
        word   = WORD_W'($urandom());
        bit_no = 0;
        for (int unsigned i = 0; i < FRAME_ITEMS; i++) begin
            lvl = (i == 1) || (i >= 3 && (i - 3) % 2 == 0);
            if (i == 0) begin
                dur = $urandom_range(100, 20000);
            end else if (i == 1) begin
                dur = header_len(flaw != FLAW_HEADER);
            end else if (i >= 4 && i != PAUSE_FALL && i % 2 == 0) begin
                dur = bit_len(word[WORD_W-1-bit_no]);
                bit_no++;
            end else begin
                dur = $urandom_range(200, 1700);
            end
            line_time = line_time + dur;
            if (flaw == FLAW_LEVEL && i == flaw_at) begin
                send_request(MODE_EDGE, !lvl, line_time);
                break;
            end
            send_request(MODE_EDGE, lvl, line_time);
            if (flaw == FLAW_HEADER && i == 1) break;
        end
    endtask

    // Level high while idle, and clear requests with odd fields
    task automatic test_idle_and_clear();
        send_request(MODE_EDGE, 1'b1, 32'hFFFF_FFFF);
        send_request(MODE_CLEAR, 1'b1, 32'hFFFF_FFFF);
        send_request(MODE_CLEAR, 1'b0, 32'h0000_0000);
    endtask

    // Header at and just inside both bounds, wrong levels after it
    task automatic test_header_bounds();
        send_request(MODE_EDGE, 1'b0, 32'd0);
        send_request(MODE_EDGE, 1'b1, 32'd8000);
        send_request(MODE_EDGE, 1'b0, 32'd10000);
        send_request(MODE_EDGE, 1'b1, 32'd19000);
        send_request(MODE_EDGE, 1'b0, 32'd20000);
        send_request(MODE_EDGE, 1'b0, 32'd20100);
        send_request(MODE_EDGE, 1'b0, 32'd30000);
        send_request(MODE_EDGE, 1'b1, 32'd38001);
        send_request(MODE_EDGE, 1'b1, 32'd38100);
        send_request(MODE_EDGE, 1'b0, 32'd40000);
        send_request(MODE_EDGE, 1'b1, 32'd48999);
        send_request(MODE_EDGE, 1'b0, 32'd49500);
        send_request(MODE_EDGE, 1'b0, 32'd50000);
    endtask

    // Header and a data bit measured across the timestamp wrap
    task automatic test_counter_wrap();
        send_request(MODE_EDGE, 1'b0, 32'hFFFF_F000);
        send_request(MODE_EDGE, 1'b1, 32'h0000_1100);
        send_request(MODE_EDGE, 1'b0, 32'h0000_1500);
        send_request(MODE_EDGE, 1'b1, 32'hFFFF_FF00);
        send_request(MODE_EDGE, 1'b0, 32'h0000_0200);
        send_request(MODE_EDGE, 1'b1, 32'h0000_0300);
        send_request(MODE_EDGE, 1'b1, 32'h0000_0400);
    endtask

    // Mostly whole frames, some spoilt ones and line noise
    task automatic test_random_frames(int unsigned n_items);
        int unsigned goal;
        int unsigned pick;
        goal = active_items + n_items;
        if ($urandom_range(0, 3) == 0) line_time = 32'hFFFF_0000 + $urandom_range(0, 65535);
        else                           line_time = $urandom();
        while (active_items < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                send_frame(FLAW_NONE, 0);
            end else if (pick < 85) begin
                send_frame(FLAW_LEVEL, $urandom_range(0, FRAME_ITEMS - 1));
            end else if (pick < 90) begin
                send_frame(FLAW_HEADER, 0);
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    if ($urandom_range(0, 1) == 0) line_time = $urandom();
                    else                           line_time = line_time + $urandom_range(0, 10000);
                    send_request($urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)),
                                 line_time);
                end
                // two high levels bring any phase back to idle
                if ($urandom_range(0, 3) != 0) begin
                    send_request(MODE_EDGE, 1'b1, line_time);
                    send_request(MODE_EDGE, 1'b1, line_time);
                end
            end
            // a held frame: a few edges that must change nothing, then release it
            if (dec_held) begin
                if ($urandom_range(0, 1) == 0) begin
                    repeat ($urandom_range(1, 3))
                        send_request(MODE_EDGE, 1'($urandom_range(0, 1)), $urandom());
                end
                send_request(MODE_CLEAR, 1'($urandom_range(0, 1)), $urandom());
            end
        end
    endtask

    task automatic test_timing_extremes();
        set_timing(16'd0, 16'hFFFF, 16'd0);
        test_random_frames(150);
        set_timing(16'd8000, 16'd9000, 16'hFFFF);
        test_random_frames(100);
        set_timing(16'd0, 16'd2, 16'd1);
        test_random_frames(100);
        set_timing(16'hFFFF, 16'hFFFF, 16'd650);
        test_random_frames(40);
    endtask

    // Receiver holds off for a long stretch while requests keep coming
    task automatic test_backpressure();
        wait_drained();
        src_idle_on   = 1'b0;
        sink_hold_len = 300;
        repeat (2) begin
            send_frame(FLAW_NONE, 0);
            send_request(MODE_CLEAR, 1'b0, line_time);
        end
        src_idle_on = 1'b1;
    endtask

    // No gaps on either side
    task automatic test_full_rate();
        set_timing(16'd8000, 16'd9000, 16'd650);
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        test_random_frames(150);
        wait_drained();
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
    endtask

    task automatic test_random_timing();
        int unsigned lo;
        repeat (4) begin
            lo = $urandom_range(0, 20000);
            set_timing(CFG_W'(lo), CFG_W'(lo + $urandom_range(0, 3000)),
                       CFG_W'($urandom_range(0, 2000)));
            test_random_frames(150);
        end
    endtask

    // Receiver: random stalls, plus a long hold-off when asked
    initial begin
        int unsigned stall;
        forever begin
            if (sink_hold_len != 0) begin
                stall         = sink_hold_len;
                sink_hold_len = 0;
                frame_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end else begin
                stall = sink_idle_on ? idle_len() : 0;
                if (stall != 0) begin
                    frame_ch.ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end else begin
                    frame_ch.ready <= 1'b1;
                    @(posedge i_clk);
                end
            end
        end
    end

    // Compare every accepted result with the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_out_item exp_item;
        if (i_rst_n === 1'b1 && frame_ch.valid === 1'b1 && frame_ch.ready === 1'b1) begin
            if (frame_expect_q.size() == 0) begin
                note_mismatch("with no request outstanding", 32'd0,
                              32'(frame_ch.data));
            end else begin
                exp_item = frame_expect_q.pop_front();
                if (frame_ch.data.frame_valid !== exp_item.frame_valid)
                    note_mismatch("frame_valid", 32'(exp_item.frame_valid),
                                  32'(frame_ch.data.frame_valid));
                if (frame_ch.data.frame_word !== exp_item.frame_word)
                    note_mismatch("frame_word", 32'(exp_item.frame_word),
                                  32'(frame_ch.data.frame_word));
            end
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        edge_ch.valid <= 1'b0;
        edge_ch.data  <= '0;
        cfg_we        <= 1'b0;
        cfg_idx       <= CFG_HDR_MIN;
        cfg_data      <= '0;
        dec_phase     = PH_IDLE;
        dec_bits      = '0;
        dec_word      = '0;
        dec_held      = 1'b0;
        dec_ref       = '0;
        cfg_hdr_min   = HDR_MIN_RESET;
        cfg_hdr_max   = HDR_MAX_RESET;
        cfg_one_thr   = ONE_THR_RESET;
        mismatch_cnt  = 0;
        active_items  = 0;
        line_time     = '0;
        src_idle_on   = 1'b1;
        sink_idle_on  = 1'b1;
        sink_hold_len = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_and_clear();
        test_header_bounds();
        test_counter_wrap();
        test_random_frames(150);
        test_backpressure();
        test_timing_extremes();
        test_full_rate();
        test_random_timing();

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (mismatch_cnt == 0 && frame_expect_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
